>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the priority queue block.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tlpq_pkg.sv
// Types and constants of the three-level priority queue.
// No dependencies.
`default_nettype none

package tlpq_pkg;

  localparam int ID_W  = 16;
  localparam int PRI_W = 2;

  // Priority codes
  localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;
  localparam logic [PRI_W-1:0] PRI_HIGH = 2'd1;
  localparam logic [PRI_W-1:0] PRI_MID  = 2'd2;
  localparam logic [PRI_W-1:0] PRI_LOW  = 2'd3;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } slot_t;

endpackage

`default_nettype wire

>>> hw/rtl/tlpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tlpq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/three_level_priority_queue.sv
// Three-level priority queue, FIFO within a level; lists the queue after each op.
// Busy while it works a command word: slot RAM reads go first to the shift pass,
// then to the listing. One result per cycle on out_valid, the last in the first
// idle cycle; a new command word is taken only while idle. Receiver cannot stall.
// Sync reset (rst_n low) clears the count, sequencer and out_valid; slot RAM is not
// cleared. Needs tlpq_pkg, tlpq_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module three_level_priority_queue #(
  parameter int DEPTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // command side
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_kind,
  input  wire  [tlpq_pkg::ID_W-1:0]    in_entry_id,
  input  wire  [tlpq_pkg::PRI_W-1:0]   in_priority_req,
  // result side
  output logic                         out_valid,
  output logic [tlpq_pkg::ID_W-1:0]    out_id,
  output logic [tlpq_pkg::PRI_W-1:0]   out_priority,
  output logic                         out_last,
  output logic                         out_queue_empty,
  output logic                         out_refused
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SLOT_W = $bits(tlpq_pkg::slot_t);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0; // wait for a command word
  localparam logic [2:0] ST_INS   = 3'd1; // backward scan, shift tail up by one
  localparam logic [2:0] ST_PLACE = 3'd2; // new entry goes to the head
  localparam logic [2:0] ST_REM   = 3'd3; // forward scan, shift tail down after match
  localparam logic [2:0] ST_LREAD = 3'd4; // issue first listing read, or the empty word if none held
  localparam logic [2:0] ST_LIST  = 3'd5; // one result word per cycle

  logic [2:0]                 state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;       // entries held
  logic [AW-1:0]              pidx_r, pidx_nxt;     // index of the word on rd_data
  logic [tlpq_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [tlpq_pkg::PRI_W-1:0] pri_r, pri_nxt;
  logic                       found_r, found_nxt;
  logic                       refused_r, refused_nxt;

  logic                       out_valid_r, out_valid_nxt;
  tlpq_pkg::slot_t            out_slot_r, out_slot_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic                       out_refused_r, out_refused_nxt;

  // slot RAM port controls
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  tlpq_pkg::slot_t            wr_slot;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [SLOT_W-1:0]          rd_q;
  tlpq_pkg::slot_t            rd_slot;

  logic                       accept;
  logic [tlpq_pkg::PRI_W-1:0] req_pri;   // priority 0 and 3 both mean lowest
  logic                       at_tail;   // rd_data holds the last valid slot
  logic                       id_hit;

  // terms for the checks
  logic                       is_full;
  logic                       full_ins;
  logic                       in_listing;
  logic                       empty_word_ok;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign rd_slot = tlpq_pkg::slot_t'(rd_q);
  assign req_pri = ((in_priority_req == tlpq_pkg::PRI_HIGH) ||
                    (in_priority_req == tlpq_pkg::PRI_MID)) ? in_priority_req
                                                             : tlpq_pkg::PRI_LOW;
  assign at_tail = (CW'(pidx_r) == (cnt_r - CW'(1)));
  assign id_hit  = (rd_slot.id == id_r);

  tlpq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pidx_nxt        = pidx_r;
    id_nxt          = id_r;
    pri_nxt         = pri_r;
    found_nxt       = found_r;
    refused_nxt     = refused_r;
    out_valid_nxt   = 1'b0;
    out_slot_nxt    = out_slot_r;
    out_last_nxt    = out_last_r;
    out_empty_nxt   = out_empty_r;
    out_refused_nxt = out_refused_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_slot         = rd_slot;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          id_nxt      = in_entry_id;
          pri_nxt     = req_pri;
          found_nxt   = 1'b0;
          refused_nxt = 1'b0;
          if (in_kind == tlpq_pkg::OP_INSERT) begin
            if (cnt_r == CW'(DEPTH)) begin
              refused_nxt = 1'b1;
              state_nxt   = ST_LREAD;
            end else if (cnt_r == '0) begin
              // empty queue: new entry is the head
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_slot.id  = in_entry_id;
              wr_slot.pri = req_pri;
              cnt_nxt    = CW'(1);
              state_nxt  = ST_LREAD;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = AW'(cnt_r - CW'(1));
              pidx_nxt  = AW'(cnt_r - CW'(1));
              state_nxt = ST_INS;
            end
          end else begin
            if (cnt_r == '0) begin
              state_nxt = ST_LREAD;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              pidx_nxt  = '0;
              state_nxt = ST_REM;
            end
          end
        end
      end

      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = pidx_r + AW'(1);
        if (rd_slot.pri > pri_r) begin
          // less urgent entry moves up one slot
          wr_slot = rd_slot;
          if (pidx_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = pidx_r - AW'(1);
            pidx_nxt  = pidx_r - AW'(1);
          end
        end else begin
          wr_slot.id  = id_r;
          wr_slot.pri = pri_r;
          cnt_nxt     = cnt_r + CW'(1);
          state_nxt   = ST_LREAD;
        end
      end

      ST_PLACE: begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        wr_slot.id  = id_r;
        wr_slot.pri = pri_r;
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = ST_LREAD;
      end

      ST_REM: begin
        if (found_r) begin
          // close the gap left by the removed entry
          wr_en   = 1'b1;
          wr_addr = pidx_r - AW'(1);
          wr_slot = rd_slot;
        end else if (id_hit) begin
          found_nxt = 1'b1;
        end
        if (at_tail) begin
          if (found_r || id_hit) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          state_nxt = ST_LREAD;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pidx_r + AW'(1);
          pidx_nxt = pidx_r + AW'(1);
        end
      end

      ST_LREAD: begin
        if (cnt_r == '0) begin
          out_valid_nxt    = 1'b1;
          out_slot_nxt.id  = '0;
          out_slot_nxt.pri = tlpq_pkg::PRI_NONE;
          out_last_nxt     = 1'b1;
          out_empty_nxt    = 1'b1;
          out_refused_nxt  = refused_r;
          state_nxt        = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          pidx_nxt  = '0;
          state_nxt = ST_LIST;
        end
      end

      ST_LIST: begin
        out_valid_nxt   = 1'b1;
        out_slot_nxt    = rd_slot;
        out_last_nxt    = at_tail;
        out_empty_nxt   = 1'b0;
        out_refused_nxt = refused_r;
        if (at_tail) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pidx_r + AW'(1);
          pidx_nxt = pidx_r + AW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk) begin
    pidx_r        <= pidx_nxt;
    id_r          <= id_nxt;
    pri_r         <= pri_nxt;
    found_r       <= found_nxt;
    refused_r     <= refused_nxt;
    out_slot_r    <= out_slot_nxt;
    out_last_r    <= out_last_nxt;
    out_empty_r   <= out_empty_nxt;
    out_refused_r <= out_refused_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_id          = out_slot_r.id;
  assign out_priority    = out_slot_r.pri;
  assign out_last        = out_last_r;
  assign out_queue_empty = out_empty_r;
  assign out_refused     = out_refused_r;

  // checks
  assign is_full       = (cnt_r == CW'(DEPTH));
  assign full_ins      = accept && (in_kind == tlpq_pkg::OP_INSERT) && is_full;
  assign in_listing    = (state_r == ST_LREAD) || (state_r == ST_LIST);
  assign empty_word_ok = out_last && (out_priority == tlpq_pkg::PRI_NONE);

  `ASSERT_IMPL(a_cnt_max, 1'b1, cnt_r <= CW'(DEPTH), "entry count above depth")
  `ASSERT_IMPL(a_no_wr_list, in_listing, !wr_en, "slot write during listing")
  `ASSERT_NEXT(a_refuse_full, full_ins, refused_r && is_full, "full insert not refused")
  `ASSERT_IMPL(a_empty_word, out_valid && out_queue_empty, empty_word_ok, "bad empty word")

endmodule

`default_nettype wire
